// ===== src/fcrc_pkg.sv =====
`timescale 1ns / 1ps

package fcrc_pkg;

    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned NUM_CHANNELS      = 4;
    localparam int unsigned FRAME_DATA_BYTES  = 8;
    localparam int unsigned FRAME_TOTAL_BYTES = 10;
    localparam int unsigned IN_DATA_W         = SAMPLE_W * NUM_CHANNELS;
    localparam int unsigned IDX_W             = 4;

    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(FRAME_DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_TOTAL_BYTES - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/fcrc_cell.sv =====
`timescale 1ns / 1ps

module fcrc_cell (
    input  logic              i_clk,
    input  fcrc_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]        i_load_byte,
    input  logic [7:0]        i_next_byte,
    output logic [7:0]        o_byte
);
    import fcrc_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.load) begin
            n_byte = i_load_byte;
        end else if (i_ctrl.shift) begin
            n_byte = i_next_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== src/fcrc_crc.sv =====
`timescale 1ns / 1ps

module fcrc_crc (
    input  logic              i_clk,
    input  fcrc_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]        i_byte,
    output logic [15:0]       o_crc
);
    import fcrc_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.load) begin
            n_crc = CRC_INIT;
        end else if (i_ctrl.shift) begin
            n_crc = crc_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

// ===== src/four_channel_frame_crc16_core.sv =====
`timescale 1ns / 1ps

// channel | dir | tdata fields (lsb first)                                | tuser | tlast
// s       | in  | channel_one, channel_two, channel_three, channel_four  | -     | -
// m       | out | frame_byte                                             | -     | frame_last
//
// each sample set gives ten bytes, one per cycle while m is not stalled: eight data
// bytes shifted out of a row of byte cells, then the crc low and high bytes
// a holding register takes the next sample set while a frame goes out, so frames
// follow with no gap
// synchronous active-low reset clears only the frame and holding valid flags and the byte index
// a stall on m freezes the cell row and crc; s is stalled while the holding register is full
module four_channel_frame_crc16_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // channel_one, channel_two, channel_three, channel_four
    input  logic [fcrc_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame_byte
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast
);
    import fcrc_pkg::*;

    logic                 r_hold_valid;
    logic                 n_hold_valid;
    logic [IN_DATA_W-1:0] r_hold;
    logic                 r_busy;
    logic                 n_busy;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_load;
    logic       w_data_phase;
    t_cell_ctrl w_ctrl;
    t_cell_ctrl w_crc_ctrl;
    logic [7:0] w_byte [FRAME_DATA_BYTES];
    logic [15:0] w_crc;

    assign s_tready     = !r_hold_valid;
    assign w_in_acc     = s_tvalid && s_tready;
    assign w_out_acc    = m_tvalid && m_tready;
    assign w_data_phase = r_idx < IDX_CRC_LO;
    assign w_load       = r_hold_valid && (!r_busy || (w_out_acc && r_idx == IDX_CRC_HI));

    assign w_ctrl.load      = w_load;
    assign w_ctrl.shift     = w_out_acc;
    assign w_crc_ctrl.load  = w_load;
    assign w_crc_ctrl.shift = w_out_acc && w_data_phase;

    always_comb begin
        n_hold_valid = r_hold_valid;
        if (w_in_acc) begin
            n_hold_valid = 1'b1;
        end else if (w_load) begin
            n_hold_valid = 1'b0;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (w_out_acc) begin
            if (r_idx == IDX_CRC_HI) begin
                n_busy = 1'b0;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_busy       <= n_busy;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hold <= s_tdata;
        end
    end

    for (genvar g = 0; g < FRAME_DATA_BYTES; g++) begin : g_cell
        logic [7:0] w_next;
        if (g == FRAME_DATA_BYTES - 1) begin : g_end
            assign w_next = 8'h00;
        end else begin : g_mid
            assign w_next = w_byte[g+1];
        end
        fcrc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_byte (r_hold[8*g +: 8]),
            .i_next_byte (w_next),
            .o_byte      (w_byte[g])
        );
    end

    fcrc_crc u_crc (
        .i_clk  (i_clk),
        .i_ctrl (w_crc_ctrl),
        .i_byte (w_byte[0]),
        .o_crc  (w_crc)
    );

    always_comb begin
        if (w_data_phase) begin
            m_tdata = w_byte[0];
        end else if (r_idx == IDX_CRC_LO) begin
            m_tdata = w_crc[7:0];
        end else begin
            m_tdata = w_crc[15:8];
        end
    end

    assign m_tvalid = r_busy;
    assign m_tlast  = (r_idx == IDX_CRC_HI);

endmodule
